// ===== src/utf8v_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared widths, limits and decode helpers for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned LenW   = 3;
	localparam int unsigned AccW   = 31;

	// Code point limits.
	localparam logic [AccW-1:0] CodeLimit  = AccW'(32'h0011_0000);
	localparam logic [AccW-1:0] CodeNonChr = AccW'(32'h0000_FFFE);
	localparam logic [AccW-1:0] SurrLo     = AccW'(32'h0000_D800);
	localparam logic [AccW-1:0] SurrHi     = AccW'(32'h0000_DFFF);

	// Byte classes.
	localparam logic [ByteW-1:0] AsciiEnd  = 8'h80;
	localparam logic [ByteW-1:0] LeadFirst = 8'hC0;
	localparam logic [ByteW-1:0] LeadEnd   = 8'hFE;
	localparam logic [1:0]       ContTag   = 2'b10;

	// Sequence length implied by a lead byte in 0xC0..0xFD.
	function automatic logic [LenW-1:0] lead_len(input logic [ByteW-1:0] b);
		logic [LenW-1:0] len;
		if (b < 8'hE0) begin
			len = 3'd2;
		end else if (b < 8'hF0) begin
			len = 3'd3;
		end else if (b < 8'hF8) begin
			len = 3'd4;
		end else if (b < 8'hFC) begin
			len = 3'd5;
		end else begin
			len = 3'd6;
		end
		return len;
	endfunction

	// Payload bits carried by a lead byte of the given length.
	function automatic logic [AccW-1:0] lead_bits(input logic [ByteW-1:0] b,
			input logic [LenW-1:0] len);
		logic [ByteW-1:0] mask;
		mask = 8'h7F >> len;
		return AccW'(b & mask);
	endfunction

	// Smallest code point that a sequence of the given length may spell.
	function automatic logic [AccW-1:0] min_code(input logic [LenW-1:0] len);
		logic [AccW-1:0] lo;
		case (len)
			3'd2:    lo = AccW'(32'h0000_0080);
			3'd3:    lo = AccW'(32'h0000_0800);
			3'd4:    lo = AccW'(32'h0001_0000);
			3'd5:    lo = AccW'(32'h0020_0000);
			3'd6:    lo = AccW'(32'h0400_0000);
			3'd7:    lo = AccW'(32'h0400_0000);
			default: lo = '0;
		endcase
		return lo;
	endfunction

endpackage

// ===== src/utf8_stream_validator_core.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_validator_core
// Checks zero-terminated byte strings as UTF-8, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on the byte channel (byte_valid, byte_ready, data_byte), one
// byte per beat. A zero byte at a character start ends the string; only
// then does a beat leave on the result channel (res_valid, res_ready,
// valid_res), with valid_res high when the whole string was valid UTF-8.
// Zero bytes inside a multi-byte sequence are errors and end nothing.
// Path: a byte is captured in the input register, decoded there by one
// level of logic (continuation shift, range compares), and the verdict is
// then registered in the result register.
// Throughput: one byte per cycle while no terminating zero stalls, set by
// the single decode stage that updates the decoder state on each byte.
// Stalls: while a verdict waits in the result register, bytes keep flowing;
// only a second terminating zero stalls in the input register, and
// byte_ready drops until the receiver takes the waiting verdict.
// Reset: arst_n clears the decoder state and both valid flags.
// ----------------------------------------------------------------------------
module utf8_stream_validator_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] data_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic       valid_res
);

	localparam int unsigned LenW = utf8v_pkg::LenW;
	localparam int unsigned AccW = utf8v_pkg::AccW;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Decoder state.
	logic            error_q;
	logic [LenW-1:0] left_q;
	logic [LenW-1:0] len_q;
	logic [AccW-1:0] acc_q;

	// Next-state values.
	logic            error_n;
	logic [LenW-1:0] left_n;
	logic [LenW-1:0] len_n;
	logic [AccW-1:0] acc_n;
	logic            emit;
	logic            advance;
	logic [AccW-1:0] acc_shift;
	logic [LenW-1:0] len_lead;
	logic            code_ok;

	// Continuation assembly and final code point check.
	assign acc_shift = {acc_q[AccW-7:0], byte_s1[5:0]};
	assign len_lead  = utf8v_pkg::lead_len(byte_s1);
	assign code_ok   = (acc_shift >= utf8v_pkg::min_code(len_q))
		&& (acc_shift < utf8v_pkg::CodeLimit)
		&& (acc_shift != utf8v_pkg::CodeNonChr)
		&& !((acc_shift >= utf8v_pkg::SurrLo) && (acc_shift <= utf8v_pkg::SurrHi));

	// Decode one byte against the current state.
	always_comb begin
		error_n = error_q;
		left_n  = left_q;
		len_n   = len_q;
		acc_n   = acc_q;
		emit    = 1'b0;
		if (left_q == '0) begin
			if (byte_s1 == '0) begin
				emit    = 1'b1;
				error_n = 1'b0;
				len_n   = '0;
				acc_n   = '0;
			end else if (error_q || byte_s1 < utf8v_pkg::AsciiEnd) begin
				error_n = error_q;
			end else if (byte_s1 < utf8v_pkg::LeadFirst || byte_s1 >= utf8v_pkg::LeadEnd) begin
				error_n = 1'b1;
				len_n   = '0;
				acc_n   = '0;
			end else begin
				len_n  = len_lead;
				left_n = len_lead - 3'd1;
				acc_n  = utf8v_pkg::lead_bits(byte_s1, len_lead);
			end
		end else if (byte_s1[7:6] != utf8v_pkg::ContTag) begin
			error_n = 1'b1;
			left_n  = '0;
			len_n   = '0;
			acc_n   = '0;
		end else begin
			left_n = left_q - 3'd1;
			acc_n  = acc_shift;
			if (left_q == 3'd1) begin
				len_n = '0;
				acc_n = '0;
				if (!code_ok) begin
					error_n = 1'b1;
				end
			end
		end
	end

	// The decode stage moves unless it must emit into a full result register that is not being taken.
	assign advance    = valid_s1 && (!emit || !res_valid || res_ready);
	assign byte_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// Decoder state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_q <= 1'b0;
			left_q  <= '0;
			len_q   <= '0;
			acc_q   <= '0;
		end else if (advance) begin
			error_q <= error_n;
			left_q  <= left_n;
			len_q   <= len_n;
			acc_q   <= acc_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance && emit) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			valid_res <= !error_q;
		end
	end

endmodule

// ===== src/utf8v_checker.sv =====
// ----------------------------------------------------------------------------
// utf8v_checker
// Port-level checks on the UTF-8 stream validator, bound into utf8_stream_validator_core.
// ----------------------------------------------------------------------------
module utf8v_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_valid,
	input logic       byte_ready,
	input logic [7:0] data_byte,
	input logic       res_valid,
	input logic       res_ready,
	input logic       valid_res
);

	// Zero bytes taken minus verdicts delivered, saturating at the top.
	logic [15:0] zero_cnt_q;
	logic        zero_in;
	logic        res_out;

	assign zero_in = byte_valid && byte_ready && (data_byte == 8'h00);
	assign res_out = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_cnt_q <= '0;
		end else if (zero_in && !res_out && zero_cnt_q != '1) begin
			zero_cnt_q <= zero_cnt_q + 16'd1;
		end else if (res_out && !zero_in && zero_cnt_q != '1) begin
			zero_cnt_q <= zero_cnt_q - 16'd1;
		end
	end

	// A waiting verdict holds its value until taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(valid_res))
		else $error("verdict changed or dropped while stalled");

	// The byte side stalls only behind a verdict that is still waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> res_valid)
		else $error("byte channel stalled with empty result register");

	// Every verdict follows a zero byte that has not yet been answered.
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> zero_cnt_q != '0)
		else $error("verdict without a terminating zero byte");

endmodule

bind utf8_stream_validator_core utf8v_checker u_utf8v_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_ready (byte_ready),
	.data_byte  (data_byte),
	.res_valid  (res_valid),
	.res_ready  (res_ready),
	.valid_res  (valid_res)
);
